// ----- hw/rtl/pit_pkg.sv -----
package pit_pkg;

   localparam int COORD_W = 12;
   localparam int RAY_W = 15;

   localparam logic [RAY_W-1:0] RAY_END_RESET = 15'd10000;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_CLEAR  = 2'd1;
   localparam logic [1:0] OP_TEST   = 2'd2;

   localparam logic STATUS_EVALUATED = 1'b0;
   localparam logic STATUS_TOO_FEW   = 1'b1;

   typedef struct packed {
      logic [1:0]         op;
      logic [COORD_W-1:0] point_x;
      logic [COORD_W-1:0] point_y;
   } req_type;

   typedef struct packed {
      logic inside_res;
      logic status;
   } rsp_type;

endpackage

// ----- hw/rtl/pit_ram.sv -----
module pit_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/point_in_polygon_test.sv -----
// Append and clear requests are handled in the idle state and can arrive back to back.
// A test request walks the stored edges with one shared orientation unit:
// each edge takes a vertex read, five turns and a decision, and the walk can
// stop early. A test with fewer than three vertices responds with STATUS_TOO_FEW.
// One request at a time.
// Synchronous reset empties the polygon and sets the ray end x to 10000.
module point_in_polygon_test import pit_pkg::*; #(
   parameter int MAX_VERTICES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [RAY_W-1:0] csr_wr_data
);

   localparam int IDX_W = $clog2(MAX_VERTICES + 1);
   localparam int ADDR_W = $clog2(MAX_VERTICES);
   localparam int PT_W = 16;
   localparam int DIFF_W = PT_W + 1;
   localparam int PROD_W = 2 * DIFF_W;
   localparam int STEP_W = 3;
   localparam int TURN_STEPS = 5;
   localparam int RAM_W = 2 * COORD_W;

   localparam logic [1:0] TURN_COL = 2'd0;
   localparam logic [1:0] TURN_CW  = 2'd1;
   localparam logic [1:0] TURN_CCW = 2'd2;

   typedef struct packed {
      logic [PT_W-1:0] x;
      logic [PT_W-1:0] y;
   } pt_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH_FIRST,
      ST_GET_FIRST,
      ST_FETCH,
      ST_GET,
      ST_TURN,
      ST_DECIDE,
      ST_DONE
   } state_type;

   function automatic logic signed [DIFF_W-1:0] diff(input logic [PT_W-1:0] u,
                                                     input logic [PT_W-1:0] v);
      return $signed({1'b0, u}) - $signed({1'b0, v});
   endfunction

   function automatic logic in_box(input pt_type a, input pt_type q, input pt_type c);
      logic [PT_W-1:0] xl;
      logic [PT_W-1:0] xh;
      logic [PT_W-1:0] yl;
      logic [PT_W-1:0] yh;
      xl = (a.x < c.x) ? a.x : c.x;
      xh = (a.x < c.x) ? c.x : a.x;
      yl = (a.y < c.y) ? a.y : c.y;
      yh = (a.y < c.y) ? c.y : a.y;
      return (q.x <= xh) && (q.x >= xl) && (q.y <= yh) && (q.y >= yl);
   endfunction

   state_type state_ff, state_in;
   logic [IDX_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [RAY_W-1:0] ray_ff, ray_in;
   pt_type q_ff, q_in;
   pt_type a_ff, a_in;
   pt_type b_ff, b_in;
   pt_type first_ff, first_in;
   logic signed [PROD_W-1:0] p1_ff, p1_in;
   logic signed [PROD_W-1:0] p2_ff, p2_in;
   logic [1:0] turn_ff [TURN_STEPS];
   logic [1:0] turn_in [TURN_STEPS];
   logic hits_ff, hits_in;
   rsp_type res_ff, res_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic ram_wr_en;
   logic [RAM_W-1:0] ram_wr_data;
   logic [RAM_W-1:0] ram_rd_data;
   pt_type rd_pt;
   pt_type e_pt;
   pt_type op_a;
   pt_type op_b;
   pt_type op_c;
   logic signed [DIFF_W-1:0] d1, d2, d3, d4;
   logic signed [PROD_W:0] orient;
   logic [1:0] turn_code;
   logic req_accept;
   logic w_apb, w_aeb, w_pae, w_pbe;
   logic edge_hit;

   pit_ram #(
      .WIDTH(RAM_W),
      .DEPTH(MAX_VERTICES)
   ) u_vertex_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(count_ff[ADDR_W-1:0]),
      .wr_data(ram_wr_data),
      .rd_addr(idx_ff[ADDR_W-1:0]),
      .rd_data(ram_rd_data)
   );

   assign ram_wr_data = {req_data.point_x, req_data.point_y};
   assign rd_pt = '{x: PT_W'(ram_rd_data[RAM_W-1:COORD_W]),
                    y: PT_W'(ram_rd_data[COORD_W-1:0])};
   assign e_pt = '{x: PT_W'(ray_ff), y: q_ff.y};

   assign req_stall = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_comb begin
      case (step_ff)
         3'd0: begin
            op_a = a_ff;
            op_b = b_ff;
            op_c = q_ff;
         end
         3'd1: begin
            op_a = a_ff;
            op_b = b_ff;
            op_c = e_pt;
         end
         3'd2: begin
            op_a = q_ff;
            op_b = e_pt;
            op_c = a_ff;
         end
         3'd3: begin
            op_a = q_ff;
            op_b = e_pt;
            op_c = b_ff;
         end
         default: begin
            op_a = a_ff;
            op_b = q_ff;
            op_c = b_ff;
         end
      endcase
   end

   assign d1 = diff(op_b.y, op_a.y);
   assign d2 = diff(op_c.x, op_b.x);
   assign d3 = diff(op_b.x, op_a.x);
   assign d4 = diff(op_c.y, op_b.y);

   assign orient = p1_ff - p2_ff;
   assign turn_code = (orient == '0) ? TURN_COL : (orient[PROD_W] ? TURN_CCW : TURN_CW);

   assign w_apb = in_box(a_ff, q_ff, b_ff);
   assign w_aeb = in_box(a_ff, e_pt, b_ff);
   assign w_pae = in_box(q_ff, a_ff, e_pt);
   assign w_pbe = in_box(q_ff, b_ff, e_pt);

   assign edge_hit = ((turn_ff[0] != turn_ff[1]) && (turn_ff[2] != turn_ff[3]))
                  || ((turn_ff[0] == TURN_COL) && w_apb)
                  || ((turn_ff[1] == TURN_COL) && w_aeb)
                  || ((turn_ff[2] == TURN_COL) && w_pae)
                  || ((turn_ff[3] == TURN_COL) && w_pbe);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      step_in = step_ff;
      ray_in = ray_ff;
      q_in = q_ff;
      a_in = a_ff;
      b_in = b_ff;
      first_in = first_ff;
      p1_in = p1_ff;
      p2_in = p2_ff;
      turn_in = turn_ff;
      hits_in = hits_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      ram_wr_en = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (csr_wr_en) begin
         ray_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_data.op)
                  OP_APPEND: begin
                     if (count_ff < IDX_W'(MAX_VERTICES)) begin
                        ram_wr_en = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_TEST: begin
                     q_in = '{x: PT_W'(req_data.point_x), y: PT_W'(req_data.point_y)};
                     hits_in = 1'b0;
                     idx_in = '0;
                     if (count_ff < IDX_W'(3)) begin
                        res_in = '{inside_res: 1'b0, status: STATUS_TOO_FEW};
                        state_in = ST_DONE;
                     end else begin
                        state_in = ST_FETCH_FIRST;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FETCH_FIRST: begin
            state_in = ST_GET_FIRST;
         end
         ST_GET_FIRST: begin
            first_in = rd_pt;
            a_in = rd_pt;
            idx_in = IDX_W'(1);
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            state_in = ST_GET;
         end
         ST_GET: begin
            // wrap the closing edge back to the first vertex
            b_in = (idx_ff == count_ff) ? first_ff : rd_pt;
            step_in = '0;
            state_in = ST_TURN;
         end
         ST_TURN: begin
            p1_in = d1 * d2;
            p2_in = d3 * d4;
            if (step_ff != '0) begin
               turn_in[step_ff - 1'b1] = turn_code;
            end
            if (step_ff == STEP_W'(TURN_STEPS)) begin
               state_in = ST_DECIDE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DECIDE: begin
            hits_in = hits_ff ^ edge_hit;
            if (edge_hit && (turn_ff[4] == TURN_COL)) begin
               res_in = '{inside_res: w_apb, status: STATUS_EVALUATED};
               state_in = ST_DONE;
            end else if (idx_ff == count_ff) begin
               res_in = '{inside_res: hits_ff ^ edge_hit, status: STATUS_EVALUATED};
               state_in = ST_DONE;
            end else begin
               a_in = b_ff;
               idx_in = idx_ff + 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = res_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ray_ff <= RAY_END_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ray_ff <= ray_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      step_ff <= step_in;
      q_ff <= q_in;
      a_ff <= a_in;
      b_ff <= b_in;
      first_ff <= first_in;
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      turn_ff <= turn_in;
      hits_ff <= hits_in;
      res_ff <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
